// ===== src/fvr_pkg.sv =====
// Shared types, constants and rounding helpers for the float vector reduce unit.
package fvr_pkg;

    typedef enum logic [1:0] {
        MODE_DOT      = 2'd0,
        MODE_SUM      = 2'd1,
        MODE_BF16_DOT = 2'd2,
        MODE_MAX      = 2'd3
    } t_mode;

    localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
    localparam int unsigned BF16_SHIFT = 16;

    function automatic logic is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    // sig[25] is the leading one, sig[0] a sticky bit; exp_b is the biased exponent.
    function automatic logic [31:0] round_pack(input logic sgn,
                                               input logic signed [10:0] exp_b,
                                               input logic [25:0] sig);
        logic [25:0] t;
        logic        lost;
        logic [7:0]  fld;
        logic [22:0] man;
        logic        inc;
        logic [10:0] sh;
        logic [30:0] mag;
        begin
            t    = sig;
            lost = 1'b0;
            fld  = 8'd0;
            sh   = 11'd0;
            if (exp_b >= 11'sd255) begin
                return {sgn, 8'hFF, 23'd0};
            end
            if (exp_b >= 11'sd1) begin
                fld = exp_b[7:0];
            end else begin
                // denormalize: shift right into the subnormal range
                sh = 11'(11'sd1 - exp_b);
                if (sh > 11'd26) begin
                    t    = 26'd0;
                    lost = |sig;
                end else begin
                    t    = sig >> sh[4:0];
                    lost = |(sig & ((26'd1 << sh[4:0]) - 26'd1));
                end
            end
            man = t[24:2];
            inc = t[1] & (t[0] | lost | man[0]);
            mag = {fld, man} + 31'(inc);
            return {sgn, mag};
        end
    endfunction

endpackage

// ===== src/fvr_mul.sv =====
// Binary32 multiplier, round to nearest even, NaN results canonical.
module fvr_mul (
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic [31:0] o_p
);

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] c;
        begin
            c = 6'd0;
            for (int i = 0; i < 48; i++) begin
                if (v[i]) c = 6'(47 - i);
            end
            return c;
        end
    endfunction

    logic        sgn;
    logic        x_zero, y_zero;
    logic [23:0] sx, sy;
    logic [8:0]  ex, ey;
    logic [47:0] prod, norm;
    logic [5:0]  lz;
    logic signed [10:0] e;

    always_comb begin
        sgn    = i_x[31] ^ i_y[31];
        x_zero = (i_x[30:0] == 31'd0);
        y_zero = (i_y[30:0] == 31'd0);
        sx     = {i_x[30:23] != 8'd0, i_x[22:0]};
        sy     = {i_y[30:23] != 8'd0, i_y[22:0]};
        ex     = (i_x[30:23] == 8'd0) ? 9'd1 : {1'b0, i_x[30:23]};
        ey     = (i_y[30:23] == 8'd0) ? 9'd1 : {1'b0, i_y[30:23]};
        prod   = 48'(sx) * 48'(sy);
        lz     = lzc48(prod);
        norm   = prod << lz;
        e      = 11'(11'(ex) + 11'(ey) - 11'd126 - 11'(lz));
        if (fvr_pkg::is_nan(i_x) || fvr_pkg::is_nan(i_y)
            || (fvr_pkg::is_inf(i_x) && y_zero) || (fvr_pkg::is_inf(i_y) && x_zero)) begin
            o_p = fvr_pkg::CANON_NAN;
        end else if (fvr_pkg::is_inf(i_x) || fvr_pkg::is_inf(i_y)) begin
            o_p = {sgn, 8'hFF, 23'd0};
        end else if (x_zero || y_zero) begin
            o_p = {sgn, 31'd0};
        end else begin
            o_p = fvr_pkg::round_pack(sgn, e, {norm[47:23], |norm[22:0]});
        end
    end

endmodule

// ===== src/fvr_add.sv =====
// Binary32 adder, round to nearest even, NaN results canonical.
module fvr_add (
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic [31:0] o_s
);

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] c;
        begin
            c = 5'd0;
            for (int i = 0; i < 28; i++) begin
                if (v[i]) c = 5'(27 - i);
            end
            return c;
        end
    endfunction

    logic [31:0] big, sml;
    logic [7:0]  eb, es, d;
    logic [26:0] lb, sm, al;
    logic [27:0] sum, norm;
    logic [4:0]  lz;
    logic signed [10:0] e;

    always_comb begin
        if (i_x[30:0] >= i_y[30:0]) begin
            big = i_x;
            sml = i_y;
        end else begin
            big = i_y;
            sml = i_x;
        end
        eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d  = eb - es;
        lb = {big[30:23] != 8'd0, big[22:0], 3'b000};
        sm = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
        if (d > 8'd26) begin
            al = 27'd1;
        end else begin
            al = (sm >> d[4:0]) | 27'(|(sm & ((27'd1 << d[4:0]) - 27'd1)));
        end
        if (big[31] == sml[31]) sum = {1'b0, lb} + {1'b0, al};
        else                    sum = {1'b0, lb} - {1'b0, al};
        lz   = lzc28(sum);
        norm = sum << lz;
        e    = 11'(11'(eb) + 11'd1 - 11'(lz));

        if (fvr_pkg::is_nan(i_x) || fvr_pkg::is_nan(i_y)
            || (fvr_pkg::is_inf(i_x) && fvr_pkg::is_inf(i_y) && (i_x[31] != i_y[31]))) begin
            o_s = fvr_pkg::CANON_NAN;
        end else if (fvr_pkg::is_inf(i_x)) begin
            o_s = i_x;
        end else if (fvr_pkg::is_inf(i_y)) begin
            o_s = i_y;
        end else if ((i_x[30:0] == 31'd0) && (i_y[30:0] == 31'd0)) begin
            o_s = {i_x[31] & i_y[31], 31'd0};
        end else if (i_x[30:0] == 31'd0) begin
            o_s = i_y;
        end else if (i_y[30:0] == 31'd0) begin
            o_s = i_x;
        end else if (sum == 28'd0) begin
            o_s = 32'd0;
        end else begin
            o_s = fvr_pkg::round_pack(big[31], e, {norm[27:3], |norm[2:0]});
        end
    end

endmodule

// ===== src/float_vector_reduce_unit.sv =====
// Top level of the float vector reduce unit: pipeline, accumulator and handshake.
//
// Reduces a stream of binary32 elements, one word per input handshake, with
// the reduction selected by the mode register (dot, sum, dot with bfloat16
// second operand, maximum). i_mode_we writes i_mode; write it only while idle.
// Input channel: i_in_valid / o_in_stall with a_value, b_value, b_half, last.
// Output channel: o_out_valid / i_out_stall with result, one word per vector,
// produced by the element marked last.
// Pipeline: input register, multiplier stage, then the add/max stage that
// updates the accumulator. A result word moves from the add stage into the
// output register. One element is accepted per cycle while the pipe is not
// stalled; the add/max feedback through the accumulator sets that rate.
// A stalled result sits in the output register; elements keep flowing until a
// second last element reaches the add stage, then the stall backs up the pipe.
// Reset clears all valids, sets mode 0 and arms a fresh vector.
module float_vector_reduce_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_mode_we,
    input  logic [1:0]  i_mode,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_a_value,
    input  logic [31:0] i_b_value,
    input  logic [15:0] i_b_half,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result
);

    fvr_pkg::t_mode r_mode;

    logic           r_s1_v, r_s1_last;
    logic [31:0]    r_s1_a, r_s1_b;
    logic [15:0]    r_s1_half;
    fvr_pkg::t_mode r_s1_mode;

    logic           r_s2_v, r_s2_last;
    logic [31:0]    r_s2_term;
    fvr_pkg::t_mode r_s2_mode;

    logic [31:0]    r_acc;
    logic           r_first;
    logic           r_out_v;
    logic [31:0]    r_out;

    logic        out_free, s2_go, s2_free, s1_go, s1_free, in_acc;
    logic [31:0] mul_b, prod, term, add_base, sum, max_start, n_acc;
    logic        st_nan, tm_nan, st_ge;
    logic [31:0] k_st, k_tm;

    assign out_free = !r_out_v || !i_out_stall;
    assign s2_go    = r_s2_v && (!r_s2_last || out_free);
    assign s2_free  = !r_s2_v || s2_go;
    assign s1_go    = r_s1_v && s2_free;
    assign s1_free  = !r_s1_v || s1_go;
    assign in_acc   = i_in_valid && s1_free;

    assign o_in_stall  = !s1_free;
    assign o_out_valid = r_out_v;
    assign o_result    = r_out;

    // multiply stage
    assign mul_b = (r_s1_mode == fvr_pkg::MODE_BF16_DOT)
                 ? ({16'd0, r_s1_half} << fvr_pkg::BF16_SHIFT) : r_s1_b;

    fvr_mul u_mul (.i_x(r_s1_a), .i_y(mul_b), .o_p(prod));

    assign term = (r_s1_mode == fvr_pkg::MODE_DOT || r_s1_mode == fvr_pkg::MODE_BF16_DOT)
                ? prod : r_s1_a;

    // accumulate stage
    assign add_base = r_first ? 32'd0 : r_acc;

    fvr_add u_add (.i_x(add_base), .i_y(r_s2_term), .o_s(sum));

    assign max_start = r_first ? r_s2_term : r_acc;
    assign st_nan    = fvr_pkg::is_nan(max_start);
    assign tm_nan    = fvr_pkg::is_nan(r_s2_term);
    assign k_st      = max_start[31] ? ~max_start : (max_start | 32'h8000_0000);
    assign k_tm      = r_s2_term[31] ? ~r_s2_term : (r_s2_term | 32'h8000_0000);
    assign st_ge     = (k_st >= k_tm);

    always_comb begin
        if (r_s2_mode == fvr_pkg::MODE_MAX) begin
            if (st_nan && tm_nan) n_acc = fvr_pkg::CANON_NAN;
            else if (st_nan)      n_acc = r_s2_term;
            else if (tm_nan)      n_acc = max_start;
            else                  n_acc = st_ge ? max_start : r_s2_term;
        end else begin
            n_acc = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= fvr_pkg::MODE_DOT;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_first <= 1'b1;
            r_acc   <= 32'd0;
        end else begin
            if (i_mode_we) r_mode <= fvr_pkg::t_mode'(i_mode);
            if (s1_free) r_s1_v <= i_in_valid;
            if (s2_free) r_s2_v <= s1_go;
            if (s2_go && r_s2_last) begin
                r_out_v <= 1'b1;
            end else if (out_free) begin
                r_out_v <= 1'b0;
            end
            if (s2_go) begin
                r_acc   <= n_acc;
                r_first <= r_s2_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_a    <= i_a_value;
            r_s1_b    <= i_b_value;
            r_s1_half <= i_b_half;
            r_s1_last <= i_last;
            r_s1_mode <= r_mode;
        end
        if (s1_go) begin
            r_s2_term <= term;
            r_s2_last <= r_s1_last;
            r_s2_mode <= r_s1_mode;
        end
        if (s2_go && r_s2_last) r_out <= n_acc;
    end

endmodule

// ===== bench/fvr_result_checker.sv =====
// Checker for the float vector reduce unit: watches both channels, predicts and compares.
module fvr_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_mode_we,
    input  logic [1:0]  i_mode,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_a_value,
    input  logic [31:0] i_b_value,
    input  logic [15:0] i_b_half,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_result,
    output int          o_fail_count,
    output int          o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    logic [31:0]    acc_bits;
    logic           vec_start;
    fvr_pkg::t_mode cur_mode;
    logic [31:0]    results_due[$];

    function automatic logic nan_f(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic inf_f(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    // value = mag * 2**e
    function automatic void split_f(input logic [31:0] v, output logic [127:0] mag,
                                    output int e);
        if (v[30:23] == 8'd0) begin
            mag = {105'd0, v[22:0]};
            e   = -149;
        end else begin
            mag = {104'd0, 1'b1, v[22:0]};
            e   = int'(v[30:23]) - 150;
        end
    endfunction

    // Round mag * 2**e to binary32, nearest-even.
    function automatic logic [31:0] round_f32(input logic sgn, input logic [127:0] mag,
                                              input int e);
        int          p;
        int          q;
        int          sh;
        logic [127:0] r;
        logic        g;
        logic        st;
        if (mag == 128'd0) return {sgn, 31'd0};
        p = 127;
        while (!mag[p]) p--;
        q = p + e - 23;
        if (q < -149) q = -149;
        sh = q - e;
        if (sh <= 0) begin
            r = mag << (-sh);
            g = 1'b0;
            st = 1'b0;
        end else if (sh > 127) begin
            r = 128'd0;
            g = 1'b0;
            st = 1'b1;
        end else begin
            r  = mag >> sh;
            g  = mag[sh-1];
            st = (sh > 1) ? |(mag & ((128'd1 << (sh - 1)) - 128'd1)) : 1'b0;
        end
        if (g && (st || r[0])) r = r + 128'd1;
        if (r[24]) begin
            r = r >> 1;
            q++;
        end
        if (!r[23]) return {sgn, 8'd0, r[22:0]};
        if (q + 150 >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, 8'(q + 150), r[22:0]};
    endfunction

    function automatic logic [31:0] mul_f32(input logic [31:0] x, input logic [31:0] y);
        logic         sgn;
        logic [127:0] mx;
        logic [127:0] my;
        int           ex;
        int           ey;
        sgn = x[31] ^ y[31];
        if (nan_f(x) || nan_f(y)) return QNAN;
        if (inf_f(x) || inf_f(y)) begin
            if (x[30:0] == 31'd0 || y[30:0] == 31'd0) return QNAN;
            return {sgn, 8'hFF, 23'd0};
        end
        split_f(x, mx, ex);
        split_f(y, my, ey);
        return round_f32(sgn, mx * my, ex + ey);
    endfunction

    function automatic logic [31:0] add_f32(input logic [31:0] x, input logic [31:0] y);
        logic [127:0] mx;
        logic [127:0] my;
        logic [127:0] mt;
        logic [127:0] sum;
        int           ex;
        int           ey;
        int           d;
        logic         sx;
        logic         sy;
        logic         sgn;
        if (nan_f(x) || nan_f(y)) return QNAN;
        if (inf_f(x) && inf_f(y)) return (x[31] != y[31]) ? QNAN : x;
        if (inf_f(x)) return x;
        if (inf_f(y)) return y;
        split_f(x, mx, ex);
        split_f(y, my, ey);
        sx = x[31];
        sy = y[31];
        if (ex < ey) begin
            mt = mx; mx = my; my = mt;
            d = ex; ex = ey; ey = d;
            sgn = sx; sx = sy; sy = sgn;
        end
        d = ex - ey;
        // far-apart operands: the small one only acts as a sticky bit
        if (d > 60) begin
            mx = mx << 60;
            ex = ex - 60;
            my = {127'd0, my != 128'd0};
            ey = ex;
            d  = 0;
        end
        mx = mx << d;
        if (sx == sy) begin
            sum = mx + my;
            sgn = sx;
        end else if (mx >= my) begin
            sum = mx - my;
            sgn = (sum == 128'd0) ? 1'b0 : sx;
        end else begin
            sum = my - mx;
            sgn = sy;
        end
        return round_f32(sgn, sum, ey);
    endfunction

    function automatic logic [31:0] rank_key(input logic [31:0] v);
        return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

    function automatic logic [31:0] max_f32(input logic [31:0] x, input logic [31:0] y);
        if (nan_f(x) && nan_f(y)) return QNAN;
        if (nan_f(x)) return y;
        if (nan_f(y)) return x;
        return (rank_key(x) >= rank_key(y)) ? x : y;
    endfunction

    // Next accumulator value after one element.
    function automatic logic [31:0] reduce_element(input logic [31:0] a,
                                                   input logic [31:0] b,
                                                   input logic [15:0] bh);
        logic [31:0] term;
        if (cur_mode == fvr_pkg::MODE_MAX) return max_f32(vec_start ? a : acc_bits, a);
        case (cur_mode)
            fvr_pkg::MODE_DOT: term = mul_f32(a, b);
            fvr_pkg::MODE_SUM: term = a;
            default:           term = mul_f32(a, {bh, 16'd0});
        endcase
        return add_f32(vec_start ? 32'd0 : acc_bits, term);
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            acc_bits  = 32'd0;
            vec_start = 1'b1;
            cur_mode  = fvr_pkg::MODE_DOT;
            o_fail_count = 0;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, i_result);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (i_result !== want) begin
                        $display("%0t: result mismatch: expected %h, actual %h",
                                 $time, want, i_result);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                acc_bits = reduce_element(i_a_value, i_b_value, i_b_half);
                vec_start = i_last;
                if (i_last) results_due.push_back(acc_bits);
            end
            if (i_mode_we) cur_mode = fvr_pkg::t_mode'(i_mode);
        end
        o_words_due = results_due.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the float vector reduce unit: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_mode_we = 1'b0;
    logic [1:0]  i_mode = fvr_pkg::MODE_DOT;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_a_value = 32'd0;
    logic [31:0] i_b_value = 32'd0;
    logic [15:0] i_b_half = 16'd0;
    logic        i_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_result;

    int fail_count;
    int words_due;
    bit quiet = 1'b0;
    int stall_left = 0;

    always #10 i_clk = ~i_clk;

    float_vector_reduce_unit dut (.*);

    fvr_result_checker u_check (
        .i_clk, .i_rst_n, .i_mode_we, .i_mode, .i_in_valid,
        .i_in_stall(o_in_stall), .i_a_value, .i_b_value, .i_b_half, .i_last,
        .i_out_valid(o_out_valid), .i_out_stall, .i_result(o_result),
        .o_fail_count(fail_count), .o_words_due(words_due)
    );

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    // receiver back-pressure in random bursts
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic [31:0] pick_f32();
        logic [31:0] odd[14] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                                 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001,
                                 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
                                 32'hFF7F_FFFF, 32'h3F80_0000};
        case ($urandom_range(0, 9))
            0:       return odd[$urandom_range(0, 13)];
            1, 2:    return $urandom;
            default: return {1'($urandom), 8'($urandom_range(110, 145)), 23'($urandom)};
        endcase
    endfunction

    // Present one element word and hold it until accepted; valid stays high
    // afterwards so the next word can follow with no gap.
    task automatic push_word(input logic [31:0] a, input logic [31:0] b,
                             input logic [15:0] bh, input logic lst);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_a_value  <= a;
        i_b_value  <= b;
        i_b_half   <= bh;
        i_last     <= lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_mode(input fvr_pkg::t_mode m);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (words_due != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_mode_we <= 1'b1;
        i_mode    <= m;
        @(negedge i_clk);
        i_mode_we <= 1'b0;
    endtask

    task automatic push_random_vector(input int len);
        for (int k = 0; k < len; k++)
            push_word(pick_f32(), pick_f32(), 16'(pick_f32() >> 16), k == len - 1);
    endtask

    initial begin
        int sent;
        int len;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // dot: overflow, inf times zero, signed zero, subnormal rounding, cancel
        push_word(32'h7F7F_FFFF, 32'h7F7F_FFFF, 16'h0, 1'b1);
        push_word(32'h7F80_0000, 32'h0000_0000, 16'h0, 1'b1);
        push_word(32'h8000_0000, 32'h3F80_0000, 16'h0, 1'b1);
        push_word(32'h0000_0001, 32'h3F00_0000, 16'h0, 1'b0);
        push_word(32'h3F80_0000, 32'h3F80_0000, 16'h0, 1'b0);
        push_word(32'hBF80_0000, 32'h3F80_0000, 16'h0, 1'b0);
        // mode switch with a vector still open: accumulator carries over
        set_mode(fvr_pkg::MODE_SUM);
        push_word(32'h3FC0_0000, 32'h0, 16'h0, 1'b1);
        push_word(32'h8000_0000, 32'h0, 16'h0, 1'b1);
        push_word(32'h7F80_0000, 32'h0, 16'h0, 1'b0);
        push_word(32'hFF80_0000, 32'h0, 16'h0, 1'b1);
        push_word(32'h7F7F_FFFF, 32'h0, 16'h0, 1'b0);
        push_word(32'h7F7F_FFFF, 32'h0, 16'h0, 1'b1);
        push_word(32'h7F80_0001, 32'h0, 16'h0, 1'b1);
        set_mode(fvr_pkg::MODE_BF16_DOT);
        push_word(32'h4040_0000, 32'h0, 16'h3F80, 1'b0);
        push_word(32'h3F80_0000, 32'h0, 16'hFFFF, 1'b1);
        push_word(32'hFFFF_FFFF, 32'h0, 16'h7F7F, 1'b1);
        set_mode(fvr_pkg::MODE_MAX);
        push_word(32'h7F80_0001, 32'h0, 16'h0, 1'b1);
        push_word(32'h7FC0_0000, 32'h0, 16'h0, 1'b0);
        push_word(32'h3F80_0000, 32'h0, 16'h0, 1'b1);
        push_word(32'h8000_0000, 32'h0, 16'h0, 1'b0);
        push_word(32'h0000_0000, 32'h0, 16'h0, 1'b1);
        push_word(32'h0000_0000, 32'h0, 16'h0, 1'b0);
        push_word(32'h8000_0000, 32'h0, 16'h0, 1'b0);
        push_word(32'hFF7F_FFFF, 32'h0, 16'h0, 1'b1);

        sent = 0;
        while (sent < 1900) begin
            set_mode(fvr_pkg::t_mode'($urandom_range(0, 3)));
            for (int v = 0; v < 30 && sent < 1900; v++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                push_random_vector(len);
                sent += len;
            end
            if (sent > 1600) quiet = 1'b1;
        end
        i_in_valid <= 1'b0;

        while (words_due != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/fvr_pkg.sv
src/fvr_mul.sv
src/fvr_add.sv
src/float_vector_reduce_unit.sv
bench/fvr_result_checker.sv
bench/tb_top.sv
